>>> design/cmq_pkg.sv
package cmq_pkg;

    // Queue and type table sizes.
    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_TYPES   = 256;

    localparam int QIDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int TYPE_IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    // Field widths of the input and result words.
    localparam int TIME_W   = 31;
    localparam int ITEM_W   = 8;
    localparam int NUMBER_W = 32;

    localparam int              CREDIT_W   = 16;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

    // Event kinds.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_SUPPLY  = 1'b1;

    // A classified event handed from the front to the back.
    typedef struct packed {
        logic                  op;
        logic [TIME_W-1:0]     event_time;
        logic [TYPE_IDX_W-1:0] type_idx;
        logic [NUMBER_W-1:0]   number;
    } cmd_t;

    // Status reported by the back.
    typedef struct packed {
        logic              clearing;
        logic [QCNT_W-1:0] q_count;
    } status_t;

endpackage

>>> design/cmq_front.sv
module cmq_front
    import cmq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [TIME_W-1:0] s_event_time,
    input  logic [ITEM_W-1:0] s_item_type,
    input  logic              clearing,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    cmd_t                  cq_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0]   fill_reg, fill_next;
    logic [NUMBER_W-1:0]   evt_cnt_reg, evt_cnt_next;
    logic                  push;
    cmd_t                  new_cmd;

    assign s_ready   = !clearing && (fill_reg != CQ_CNT_W'(CQ_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = cq_reg[rd_ptr_reg];

    // Every word gets its sequence number on acceptance; the type is reduced to a table index.
    always_comb begin
        new_cmd.op         = s_op;
        new_cmd.event_time = s_event_time;
        new_cmd.type_idx   = TYPE_IDX_W'(32'(s_item_type) % NUM_TYPES);
        new_cmd.number     = evt_cnt_reg;
    end

    always_comb begin
        wr_ptr_next  = push ? ((wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1)
                            : wr_ptr_reg;
        rd_ptr_next  = cmd_pop ? ((rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                               : rd_ptr_reg;
        fill_next    = fill_reg + CQ_CNT_W'(push) - CQ_CNT_W'(cmd_pop);
        evt_cnt_next = push ? evt_cnt_reg + 1'b1 : evt_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            evt_cnt_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            evt_cnt_reg <= evt_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cq_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/cmq_back.sv
module cmq_back
    import cmq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output status_t             status,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NUMBER_W-1:0] m_event_number,
    output logic [TIME_W-1:0]   m_wait_time,
    output logic                m_dropped,
    output logic                m_last
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CMD,
        S_HEAD,
        S_HTYPE,
        S_HCRED,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [TYPE_IDX_W-1:0] type_idx;
        logic [TIME_W-1:0]     arrival;
        logic [NUMBER_W-1:0]   number;
    } pend_t;

    // Pending request store and per-type credit table.
    pend_t               pend_mem [QUEUE_DEPTH];
    logic [CREDIT_W-1:0] credit_mem [NUM_TYPES];

    pend_t                 pend_rdata_reg;
    logic [CREDIT_W-1:0]   credit_rdata_reg;
    logic                  pend_we;
    logic [QIDX_W-1:0]     pend_waddr;
    pend_t                 pend_wdata;
    logic                  credit_we;
    logic [TYPE_IDX_W-1:0] credit_waddr, credit_raddr;
    logic [CREDIT_W-1:0]   credit_wdata;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [QIDX_W-1:0]     head_reg, head_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    logic [QCNT_W-1:0]     n_reg, n_next;
    logic [TYPE_IDX_W-1:0] clr_idx_reg, clr_idx_next;

    logic                  hold_valid_reg, hold_valid_next;
    logic [NUMBER_W-1:0]   hold_num_reg, hold_num_next;
    logic [TIME_W-1:0]     hold_wait_reg, hold_wait_next;
    logic                  hold_drop_reg, hold_drop_next;

    logic                  m_valid_reg, m_valid_next;
    logic [NUMBER_W-1:0]   m_num_reg, m_num_next;
    logic [TIME_W-1:0]     m_wait_reg, m_wait_next;
    logic                  m_drop_reg, m_drop_next;
    logic                  m_last_reg, m_last_next;

    logic                  out_free;
    logic [QCNT_W:0]       tail_sum;
    logic [QIDX_W-1:0]     tail;
    logic [TIME_W-1:0]     wait_calc;

    assign out_free = !m_valid_reg || m_ready;

    assign tail_sum = (QCNT_W+1)'(head_reg) + (QCNT_W+1)'(count_reg);
    assign tail     = (tail_sum >= (QCNT_W+1)'(QUEUE_DEPTH))
                      ? QIDX_W'(tail_sum - (QCNT_W+1)'(QUEUE_DEPTH))
                      : QIDX_W'(tail_sum);

    assign wait_calc = (cmd_reg.event_time >= pend_rdata_reg.arrival)
                       ? cmd_reg.event_time - pend_rdata_reg.arrival : '0;

    assign credit_raddr = (state_reg == S_IDLE) ? cmd.type_idx : pend_rdata_reg.type_idx;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        clr_idx_next    = clr_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_num_next   = hold_num_reg;
        hold_wait_next  = hold_wait_reg;
        hold_drop_next  = hold_drop_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_num_next      = m_num_reg;
        m_wait_next     = m_wait_reg;
        m_drop_next     = m_drop_reg;
        m_last_next     = m_last_reg;
        cmd_pop         = 1'b0;
        pend_we         = 1'b0;
        pend_waddr      = tail;
        pend_wdata      = '{type_idx: cmd_reg.type_idx, arrival: cmd_reg.event_time,
                            number: cmd_reg.number};
        credit_we       = 1'b0;
        credit_waddr    = pend_rdata_reg.type_idx;
        credit_wdata    = credit_rdata_reg - 1'b1;

        case (state_reg)
            S_CLEAR: begin
                credit_we    = 1'b1;
                credit_waddr = clr_idx_reg;
                credit_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == TYPE_IDX_W'(NUM_TYPES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    n_next     = '0;
                    state_next = S_CMD;
                end
            end
            S_CMD: begin
                if (cmd_reg.op == OP_SUPPLY) begin
                    credit_we    = 1'b1;
                    credit_waddr = cmd_reg.type_idx;
                    credit_wdata = (credit_rdata_reg == CREDIT_MAX)
                                   ? credit_rdata_reg : credit_rdata_reg + 1'b1;
                end else if (count_reg == QCNT_W'(QUEUE_DEPTH)) begin
                    // The result is held back until it is known whether it is the last one.
                    hold_valid_next = 1'b1;
                    hold_num_next   = cmd_reg.number;
                    hold_wait_next  = '0;
                    hold_drop_next  = 1'b1;
                    n_next          = QCNT_W'(1);
                end else begin
                    pend_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_HEAD;
            end
            S_HEAD: begin
                if (count_reg == '0 || n_reg == QCNT_W'(QUEUE_DEPTH)) begin
                    state_next = S_FLUSH;
                end else begin
                    state_next = S_HTYPE;
                end
            end
            S_HTYPE: begin
                state_next = S_HCRED;
            end
            S_HCRED: begin
                if (credit_rdata_reg == '0) begin
                    state_next = S_FLUSH;
                end else if (!hold_valid_reg || out_free) begin
                    credit_we = 1'b1;
                    if (hold_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_num_next   = hold_num_reg;
                        m_wait_next  = hold_wait_reg;
                        m_drop_next  = hold_drop_reg;
                        m_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_num_next   = pend_rdata_reg.number;
                    hold_wait_next  = wait_calc;
                    hold_drop_next  = 1'b0;
                    head_next       = (head_reg == QIDX_W'(QUEUE_DEPTH - 1))
                                      ? '0 : head_reg + 1'b1;
                    count_next      = count_reg - 1'b1;
                    n_next          = n_reg + 1'b1;
                    state_next      = S_HEAD;
                end
            end
            S_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_num_next      = hold_num_reg;
                    m_wait_next     = hold_wait_reg;
                    m_drop_next     = hold_drop_reg;
                    m_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            head_reg       <= '0;
            count_reg      <= '0;
            n_reg          <= '0;
            clr_idx_reg    <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            clr_idx_reg    <= clr_idx_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        hold_num_reg  <= hold_num_next;
        hold_wait_reg <= hold_wait_next;
        hold_drop_reg <= hold_drop_next;
        m_num_reg     <= m_num_next;
        m_wait_reg    <= m_wait_next;
        m_drop_reg    <= m_drop_next;
        m_last_reg    <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        pend_rdata_reg <= pend_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (credit_we) begin
            credit_mem[credit_waddr] <= credit_wdata;
        end
        credit_rdata_reg <= credit_mem[credit_raddr];
    end

    assign status.clearing = (state_reg == S_CLEAR);
    assign status.q_count  = count_reg;

    assign m_valid        = m_valid_reg;
    assign m_event_number = m_num_reg;
    assign m_wait_time    = m_wait_reg;
    assign m_dropped      = m_drop_reg;
    assign m_last         = m_last_reg;

endmodule

>>> design/in_order_credit_matched_queue_core.sv
// In-order credit-matched request queue. Each input word is either a supply event, which adds
// one credit (saturating at 65535) to its item type, or a request event, which joins an
// in-order queue of QUEUE_DEPTH entries; a request that finds the queue full is refused and
// reported once with dropped set. After every event the queue head is released for as long as
// its type holds a credit, each release giving the request's event number and its wait time
// (current time minus arrival, clamped at zero). The last result word of an event carries last;
// an event that releases and drops nothing gives no word. After reset the credit table is
// cleared one entry per cycle, so s_ready stays low until the clear is done. The front takes
// words into a two-entry queue whenever there is room. The back sequencer works on one event
// at a time and ends it with the queue empty, at the per-event result limit, or at a head
// whose type has no credit. Each release goes through a head read, a credit read and a credit
// update in the credit table, and a result that m_ready holds back stalls the sequencer.
module in_order_credit_matched_queue_core
    import cmq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [TIME_W-1:0]   s_event_time,
    input  logic [ITEM_W-1:0]   s_item_type,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NUMBER_W-1:0] m_event_number,
    output logic [TIME_W-1:0]   m_wait_time,
    output logic                m_dropped,
    output logic                m_last
);

    // Classified events waiting for the back, and the back's status.
    logic    cmd_valid;
    logic    cmd_pop;
    cmd_t    cmd;
    status_t status;

    // The front numbers every accepted word and buffers it.
    cmq_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_event_time (s_event_time),
        .s_item_type  (s_item_type),
        .clearing     (status.clearing),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // The back applies each event to the credit table and the queue, then drains the head.
    cmq_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_number (m_event_number),
        .m_wait_time    (m_wait_time),
        .m_dropped      (m_dropped),
        .m_last         (m_last)
    );

`ifndef NO_ASSERTIONS
    // No word may be taken while the credit table is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("input accepted during credit clear");

    // The queue occupancy never exceeds its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // A refused request is the only result of its event and has no wait time.
    a_drop_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dropped) |-> (m_last && m_wait_time == '0))
        else $error("malformed drop result");
`endif

endmodule

>>> sim/tb_in_order_credit_matched_queue_core.sv
// Testbench for the in-order credit-matched request queue.
//
// Every input word is either a supply, which adds one credit to its item type, or a request,
// which waits in an in-order queue until its type has a credit. A shadow copy of the queue,
// of the credit table and of the event counter is updated each time the block takes an input
// word. That copy works out which result words the event must release, in order, and they
// are appended to a list of owed words. Each result word that the block hands over is then
// compared field by field with the oldest owed word.
//
// The block takes no configuration, so the run is one stream of events made of three tests:
// directed matching at the field extremes, a fill of the queue up to a refused request and a
// 64-word release burst, and random traffic under three idling patterns.
module tb_in_order_credit_matched_queue_core;
    import cmq_pkg::*;

    localparam int HALF_PERIOD = 6;

    // Cycles with work waiting and no word moving on either side before the run is abandoned.
    // The longest quiet stretch of a correct block is the credit table clear after reset, so this
    // leaves a wide margin.
    localparam int STALL_LIMIT = 4000;

    // Cycles allowed after the last owed word for stray extra words to show up.
    localparam int TAIL_CYCLES = 50;

    // One owed result word: the request released or refused and how long it waited.
    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [TIME_W-1:0]   waited;
        logic                dropped;
        logic                last;
    } release_word_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_op           = OP_REQUEST;
    logic [TIME_W-1:0]   s_event_time   = '0;
    logic [ITEM_W-1:0]   s_item_type    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [NUMBER_W-1:0] m_event_number;
    logic [TIME_W-1:0]   m_wait_time;
    logic                m_dropped;
    logic                m_last;

    // Shadow state: the pending requests in a circular store, the credit table and the
    // running event counter.
    logic [TYPE_IDX_W-1:0] pend_type    [QUEUE_DEPTH];
    logic [TIME_W-1:0]     pend_arrival [QUEUE_DEPTH];
    logic [NUMBER_W-1:0]   pend_number  [QUEUE_DEPTH];
    int                    pend_head    = 0;
    int                    pend_count   = 0;
    logic [CREDIT_W-1:0]   credits      [NUM_TYPES];
    logic [NUMBER_W-1:0]   event_seq    = '0;

    // Result words owed by the block, oldest first.
    release_word_t release_q [$];

    // Percent of cycles in which the sender and the receiver hold back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Running time stamp of the stimulus, kept nondecreasing unless a test says otherwise.
    logic [TIME_W-1:0] now_time = '0;

    int fault_count = 0;
    int stall_count = 0;

    in_order_credit_matched_queue_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_event_time   (s_event_time),
        .s_item_type    (s_item_type),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_number (m_event_number),
        .m_wait_time    (m_wait_time),
        .m_dropped      (m_dropped),
        .m_last         (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    initial begin
        foreach (credits[i]) credits[i] = '0;
    end

    // The receiver draws a fresh ready at every edge, so stalls can land on any cycle of the
    // block's release sequence.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic log_mismatch(input string msg);
        fault_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Applies one accepted event to the shadow state and appends the words it must release.
    // The last word of the event is held back until the event is fully worked out, so that
    // its last flag can be set before it joins the list.
    task automatic match_and_release(input logic op, input logic [TIME_W-1:0] t,
                                     input logic [ITEM_W-1:0] ty);
        release_word_t held;
        release_word_t word;
        logic          have_held;
        int            idx;
        int            slot;
        int            produced;
        idx       = int'(ty) % NUM_TYPES;
        have_held = 1'b0;
        produced  = 0;
        held      = '0;
        word      = '0;
        if (op == OP_SUPPLY) begin
            if (credits[idx] != CREDIT_MAX) begin
                credits[idx] = credits[idx] + 1'b1;
            end
        end else if (pend_count >= QUEUE_DEPTH) begin
            // A full queue refuses the request with a single flagged word.
            held.number  = event_seq;
            held.waited  = '0;
            held.dropped = 1'b1;
            have_held    = 1'b1;
            produced     = 1;
        end else begin
            slot               = (pend_head + pend_count) % QUEUE_DEPTH;
            pend_type[slot]    = TYPE_IDX_W'(idx);
            pend_arrival[slot] = t;
            pend_number[slot]  = event_seq;
            pend_count++;
        end
        event_seq = event_seq + 1'b1;

        // Release from the head for as long as the head's type holds a credit, up to QUEUE_DEPTH words.
        while (pend_count > 0 && produced < QUEUE_DEPTH
               && credits[pend_type[pend_head]] != '0) begin
            credits[pend_type[pend_head]] = credits[pend_type[pend_head]] - 1'b1;
            word.number  = pend_number[pend_head];
            word.waited  = (t >= pend_arrival[pend_head]) ? t - pend_arrival[pend_head] : '0;
            word.dropped = 1'b0;
            word.last    = 1'b0;
            if (have_held) begin
                release_q = {release_q, held};
            end
            held      = word;
            have_held = 1'b1;
            produced++;
            pend_head = (pend_head + 1) % QUEUE_DEPTH;
            pend_count--;
        end
        if (have_held) begin
            held.last = 1'b1;
            release_q = {release_q, held};
        end
    endtask

    // Offers one input word and returns at the edge where it is taken. It is entered just
    // after a rising edge. Valid is only lowered when the sender chooses to idle, so a
    // back-to-back word keeps valid high without a drop in between.
    task automatic send_event(input logic op, input logic [TIME_W-1:0] t,
                              input logic [ITEM_W-1:0] ty);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_event_time <= t;
        s_item_type  <= ty;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        match_and_release(op, t, ty);
    endtask

    // Each result word taken by the receiver is matched against the oldest owed word.
    always @(posedge aclk) begin
        release_word_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (release_q.size() == 0) begin
                log_mismatch($sformatf("word for event %0d with nothing owed", m_event_number));
            end else begin
                owed = release_q.pop_front();
                if (m_event_number !== owed.number) begin
                    log_mismatch($sformatf("event_number %0d, owed %0d",
                                           m_event_number, owed.number));
                end
                if (m_wait_time !== owed.waited) begin
                    log_mismatch($sformatf("wait_time %0d for event %0d, owed %0d",
                                           m_wait_time, owed.number, owed.waited));
                end
                if (m_dropped !== owed.dropped) begin
                    log_mismatch($sformatf("dropped %b for event %0d, owed %b",
                                           m_dropped, owed.number, owed.dropped));
                end
                if (m_last !== owed.last) begin
                    log_mismatch($sformatf("last %b for event %0d, owed %b",
                                           m_last, owed.number, owed.last));
                end
            end
        end
    end

    // Watchdog: counts cycles in which work is waiting (an offered word or an owed word) and
    // nothing moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (!s_valid && release_q.size() == 0)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("tb_in_order_credit_matched_queue_core NOT OK");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Plain matching at the edges of the fields: a request that waits for its credit, a
    // credit that waits for its request, the widest and the smallest time stamps, a supply
    // time earlier than the arrival (clamped to a zero wait), and alternating type bits.
    task automatic test_basic_matching();
        send_event(OP_REQUEST, 31'd0, 8'h00);
        send_event(OP_SUPPLY,  31'd5, 8'h00);
        send_event(OP_REQUEST, 31'd1000, 8'h07);
        send_event(OP_SUPPLY,  31'd10, 8'h07);
        send_event(OP_SUPPLY,  31'd20, 8'hFF);
        send_event(OP_REQUEST, {TIME_W{1'b1}}, 8'hFF);
        send_event(OP_REQUEST, 31'd0, 8'hAA);
        send_event(OP_SUPPLY,  {TIME_W{1'b1}}, 8'hAA);
        send_event(OP_SUPPLY,  31'h2AAA_AAAA, 8'h55);
        send_event(OP_SUPPLY,  31'h2AAA_AAAA, 8'h55);
        send_event(OP_REQUEST, 31'h5555_5555, 8'h55);
        send_event(OP_REQUEST, 31'h5555_5555, 8'h55);
        now_time = 31'd100;
    endtask

    // One request with no credit blocks the head while 63 requests of a credited type pile up
    // behind it. The queue is then full, so the next request is refused. A single credit for
    // the head type finally lets all 64 entries go in one burst.
    task automatic test_queue_full();
        repeat (QUEUE_DEPTH - 1) begin
            send_event(OP_SUPPLY, now_time, 8'h20);
        end
        send_event(OP_REQUEST, now_time, 8'h10);
        repeat (QUEUE_DEPTH - 1) begin
            now_time = now_time + 31'd3;
            send_event(OP_REQUEST, now_time, 8'h20);
        end
        send_event(OP_REQUEST, now_time, 8'h30);
        now_time = now_time + 31'd50;
        send_event(OP_SUPPLY, now_time, 8'h10);
    endtask

    // Random events over a few hot types, so that most requests meet a credit sooner or later.
    // Stray types appear mostly as supplies, since a stray request would block the head. When
    // the queue gets deep, the head type is fed now and then so the queue keeps moving while
    // still reaching the full state at times.
    task automatic test_random_traffic(input int count);
        logic [ITEM_W-1:0] hot [4];
        logic [ITEM_W-1:0] ty;
        logic [TIME_W-1:0] t;
        logic              op;
        foreach (hot[i]) hot[i] = ITEM_W'($urandom_range(255));
        repeat (count) begin
            if ($urandom_range(99) < 3) begin
                now_time = TIME_W'($urandom);
            end else begin
                now_time = now_time + TIME_W'($urandom_range(20));
            end
            t = now_time;
            if ($urandom_range(99) < 4) begin
                t = now_time - TIME_W'($urandom_range(1, 50));
            end
            op = $urandom_range(1) ? OP_SUPPLY : OP_REQUEST;
            ty = hot[$urandom_range(3)];
            if (pend_count > 40 && $urandom_range(1) == 1) begin
                op = OP_SUPPLY;
                ty = ITEM_W'(pend_type[pend_head]);
            end else if ($urandom_range(99) < 12) begin
                ty = ITEM_W'($urandom_range(255));
                if ($urandom_range(3) != 0) begin
                    op = OP_SUPPLY;
                end
            end
            send_event(op, t, ty);
        end
    endtask

    initial begin
        send_idle_pct = 38;
        recv_idle_pct = 56;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // The block clears its credit table after reset; the first word simply waits on
        // s_ready until that is done.
        test_basic_matching();
        test_queue_full();
        test_random_traffic(73);

        send_idle_pct = 56;
        recv_idle_pct = 38;
        test_random_traffic(73);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(73);

        s_valid <= 1'b0;
        while (release_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fault_count == 0) begin
            $display("tb_in_order_credit_matched_queue_core OK");
        end else begin
            $display("tb_in_order_credit_matched_queue_core NOT OK");
        end
        $finish;
    end

endmodule
